// File: rtl/chbd_pkg.sv
// Shared types, character codes and helpers for the chunked body decoder.
package chbd_pkg;

    // Parameter defaults
    localparam int LINE_LIMIT_DEF = 1024;
    localparam int SIZE_BITS_DEF  = 32;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int BODY_W   = 32;
    localparam int CLEN_W   = 32;
    localparam int STATUS_W = 3;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    // Input operation codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_DATA_CRLF,
        PH_TRAILER,
        PH_DONE
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_COMPLETE,
        ST_REFUSED,
        ST_FORMAT,
        ST_LENGTH,
        ST_SYNTAX,
        ST_LARGE,
        ST_HALTED
    } status_t;

    // One result item
    typedef struct packed {
        status_t            status;
        logic [CLEN_W-1:0]  chunk_length;
        logic               size_ready;
        logic               chunk_end;
        logic               payload_valid;
        logic [BYTE_W-1:0]  payload_byte;
    } result_t;

    // Decode one hex character: bit 4 set when valid, low nibble is the value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        logic [7:0] t;
        begin
            r = '0;
            t = '0;
            if (c >= CH_0 && c <= CH_9) begin
                r = {1'b1, c[3:0]};
            end else if (c >= CH_A_LO && c <= CH_F_LO) begin
                t = c - CH_A_LO + HEX_TEN;
                r = {1'b1, t[3:0]};
            end else if (c >= CH_A_UP && c <= CH_F_UP) begin
                t = c - CH_A_UP + HEX_TEN;
                r = {1'b1, t[3:0]};
            end
            return r;
        end
    endfunction

endpackage

// File: rtl/chbd_decoder.sv
// Parser state, limit register and per-byte decode logic.
module chbd_decoder
    import chbd_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [BODY_W-1:0]  cfg_wdata,
    input  logic               step,
    input  logic               op,
    input  logic [BYTE_W-1:0]  in_byte,
    output result_t            res
);

    localparam int LW   = $clog2(LINE_LIMIT + 1);
    localparam int WIDE = (SIZE_BITS > BODY_W) ? SIZE_BITS : BODY_W;

    logic [BODY_W-1:0]    max_body_reg;
    phase_t               phase_reg, phase_next;
    logic                 pending_cr_reg, pending_cr_next;
    logic [LW-1:0]        line_len_reg, line_len_next;
    logic [SIZE_BITS-1:0] acc_reg, acc_next;
    logic                 digit_reg, digit_next;
    logic                 in_ext_reg, in_ext_next;
    logic                 bad_char_reg, bad_char_next;
    logic                 overflow_reg, overflow_next;
    logic [SIZE_BITS-1:0] left_reg, left_next;
    logic [BODY_W-1:0]    body_reg, body_next;
    status_t              sticky_reg, sticky_next;

    logic [4:0]           hex;
    logic [SIZE_BITS-1:0] left_dec;
    logic [WIDE-1:0]      size_w;
    logic [WIDE-1:0]      lim_w;
    logic [WIDE-1:0]      body_w;
    logic                 too_large;

    assign hex    = hex_digit(in_byte);
    assign size_w = WIDE'(acc_reg);
    assign lim_w  = WIDE'(max_body_reg);
    assign body_w = WIDE'(body_reg);
    assign left_dec = (left_reg != '0) ? left_reg - 1'b1 : left_reg;

    // Limit check against total payload so far
    assign too_large = (max_body_reg != '0) &&
                       ((body_w > lim_w) || (size_w > lim_w - body_w));

    // Next state and result for the byte at the input
    always_comb begin
        phase_next      = phase_reg;
        pending_cr_next = pending_cr_reg;
        line_len_next   = line_len_reg;
        acc_next        = acc_reg;
        digit_next      = digit_reg;
        in_ext_next     = in_ext_reg;
        bad_char_next   = bad_char_reg;
        overflow_next   = overflow_reg;
        left_next       = left_reg;
        body_next       = body_reg;
        sticky_next     = sticky_reg;
        res             = '0;
        res.status      = ST_OK;

        if (op == OP_RESTART) begin
            phase_next      = PH_SIZE;
            pending_cr_next = 1'b0;
            line_len_next   = '0;
            acc_next        = '0;
            digit_next      = 1'b0;
            in_ext_next     = 1'b0;
            bad_char_next   = 1'b0;
            overflow_next   = 1'b0;
            left_next       = '0;
            body_next       = '0;
            sticky_next     = ST_OK;
        end else if (sticky_reg != ST_OK) begin
            res.status = ST_HALTED;
        end else if (phase_reg == PH_DONE) begin
            res.status = ST_REFUSED;
        end else if (phase_reg == PH_DATA) begin
            // Pass payload through and count it down
            res.payload_byte  = in_byte;
            res.payload_valid = 1'b1;
            if (body_reg != '1) begin
                body_next = body_reg + 1'b1;
            end
            left_next = left_dec;
            if (left_dec == '0) begin
                res.chunk_end   = 1'b1;
                phase_next      = PH_DATA_CRLF;
                pending_cr_next = 1'b0;
            end
        end else if (phase_reg == PH_DATA_CRLF) begin
            // Expect CR LF after the payload
            if (!pending_cr_reg) begin
                if (in_byte != CH_CR) begin
                    res.status = ST_FORMAT;
                end else begin
                    pending_cr_next = 1'b1;
                end
            end else if (in_byte != CH_LF) begin
                res.status = ST_FORMAT;
            end else begin
                pending_cr_next = 1'b0;
                line_len_next   = '0;
                acc_next        = '0;
                digit_next      = 1'b0;
                in_ext_next     = 1'b0;
                bad_char_next   = 1'b0;
                overflow_next   = 1'b0;
                left_next       = '0;
                phase_next      = PH_SIZE;
            end
        end else if (pending_cr_reg) begin
            // Close a size or trailer line
            pending_cr_next = 1'b0;
            if (in_byte != CH_LF) begin
                res.status = ST_FORMAT;
            end else if (phase_reg == PH_TRAILER) begin
                if (line_len_reg != '0) begin
                    res.status = ST_FORMAT;
                end else begin
                    phase_next = PH_DONE;
                    res.status = ST_COMPLETE;
                end
            end else if (!digit_reg) begin
                res.status = ST_SYNTAX;
            end else if (overflow_reg) begin
                res.status = ST_LENGTH;
            end else if (bad_char_reg) begin
                res.status = ST_SYNTAX;
            end else if ((acc_reg != '0) && too_large) begin
                res.status = ST_LARGE;
            end else begin
                res.size_ready   = 1'b1;
                res.chunk_length = size_w[CLEN_W-1:0];
                line_len_next    = '0;
                acc_next         = '0;
                digit_next       = 1'b0;
                in_ext_next      = 1'b0;
                bad_char_next    = 1'b0;
                overflow_next    = 1'b0;
                left_next        = acc_reg;
                phase_next       = (acc_reg == '0) ? PH_TRAILER : PH_DATA;
            end
        end else if (in_byte == CH_CR) begin
            pending_cr_next = 1'b1;
        end else if (in_byte == CH_LF) begin
            res.status = ST_FORMAT;
        end else if (line_len_reg >= LW'(LINE_LIMIT)) begin
            res.status = ST_LENGTH;
        end else begin
            // Count the line and accumulate size digits
            line_len_next = line_len_reg + 1'b1;
            if (phase_reg == PH_SIZE && !in_ext_reg) begin
                if (in_byte == CH_SEMI) begin
                    in_ext_next = 1'b1;
                end else begin
                    digit_next = 1'b1;
                    if (!bad_char_reg && !overflow_reg) begin
                        if (!hex[4]) begin
                            bad_char_next = 1'b1;
                        end else if (acc_reg[SIZE_BITS-1 -: 4] != '0) begin
                            overflow_next = 1'b1;
                        end else begin
                            acc_next = {acc_reg[SIZE_BITS-5:0], hex[3:0]};
                        end
                    end
                end
            end
        end

        // Latch the first framing fault
        if (res.status == ST_FORMAT || res.status == ST_LENGTH ||
            res.status == ST_SYNTAX || res.status == ST_LARGE) begin
            sticky_next = res.status;
        end
    end

    // Limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_body_reg <= '0;
        end else if (cfg_we) begin
            max_body_reg <= cfg_wdata;
        end
    end

    // Parser state, advanced once per accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SIZE;
            pending_cr_reg <= 1'b0;
            line_len_reg   <= '0;
            acc_reg        <= '0;
            digit_reg      <= 1'b0;
            in_ext_reg     <= 1'b0;
            bad_char_reg   <= 1'b0;
            overflow_reg   <= 1'b0;
            left_reg       <= '0;
            body_reg       <= '0;
            sticky_reg     <= ST_OK;
        end else if (step) begin
            phase_reg      <= phase_next;
            pending_cr_reg <= pending_cr_next;
            line_len_reg   <= line_len_next;
            acc_reg        <= acc_next;
            digit_reg      <= digit_next;
            in_ext_reg     <= in_ext_next;
            bad_char_reg   <= bad_char_next;
            overflow_reg   <= overflow_next;
            left_reg       <= left_next;
            body_reg       <= body_next;
            sticky_reg     <= sticky_next;
        end
    end

endmodule

// File: rtl/chbd_out_stage.sv
// Result register with valid/ready handshake toward the output stream.
module chbd_out_stage
    import chbd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res_in,
    input  logic    out_ready,
    output logic    in_ready,
    output logic    out_valid,
    output result_t res_out
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // Free when empty or draining this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    // Hold valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

// File: rtl/chunked_body_stream_decoder_unit.sv
// Each input transfer gives its result on m_tvalid in the next cycle.
// Throughput: one byte per cycle; s_tready drops only while the result
// register is full and m_tready is low.
// Each byte is decoded by combinational logic between the parser state and
// the result register. Synchronous active-low reset clears the parser state,
// sticky error, body count, the body size limit and the result valid flag.
module chunked_body_stream_decoder_unit
    import chbd_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration: body size limit
    input  logic               cfg_we,
    input  logic [BODY_W-1:0]  cfg_wdata,
    // Input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] in_byte
    input  logic               s_tuser,   // [0] operation
    // Result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,   // [7:0] payload_byte, [39:8] chunk_length,
                                          // [42:40] status, [47:43] zero
    output logic [1:0]         m_tuser,   // [0] payload_valid, [1] size_ready
    output logic               m_tlast    // chunk_end
);

    logic    s_accept;
    result_t dec_res;
    result_t out_res;

    assign s_accept = s_tvalid && s_tready;

    chbd_decoder #(
        .LINE_LIMIT (LINE_LIMIT),
        .SIZE_BITS  (SIZE_BITS)
    ) u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (s_accept),
        .op        (s_tuser),
        .in_byte   (s_tdata),
        .res       (dec_res)
    );

    chbd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_accept),
        .res_in    (dec_res),
        .out_ready (m_tready),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .res_out   (out_res)
    );

    // Pack result fields onto the stream
    assign m_tdata = {5'b0, out_res.status, out_res.chunk_length, out_res.payload_byte};
    assign m_tuser = {out_res.size_ready, out_res.payload_valid};
    assign m_tlast = out_res.chunk_end;

`ifndef ASSERT_OFF
    // A restart gives an all-zero result in the next cycle
    a_restart_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == OP_RESTART |=> m_tvalid && out_res == '0)
        else $error("restart result not cleared");

    // Payload and size results carry status ok
    a_flags_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_res.payload_valid || out_res.size_ready) |->
            out_res.status == ST_OK)
        else $error("flagged result with non-ok status");

    // Payload and size line never complete on the same byte; chunk_end comes only with payload
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_res.payload_valid && out_res.size_ready) &&
            (!out_res.chunk_end || out_res.payload_valid))
        else $error("inconsistent result flags");

    // Every accepted byte shows up as a result next cycle
    a_accept_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted transfer produced no result");
`endif

endmodule

// File: test/chbd_stream_checker.sv
// Checker for the chunked body decoder: predicts every result and compares each transfer.
module chbd_stream_checker
    import chbd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [BODY_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] in_byte
    input  logic              s_tuser,   // [0] operation
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [47:0]       m_tdata,   // [7:0] payload_byte, [39:8] chunk_length,
                                         // [42:40] status, [47:43] zero
    input  logic [1:0]        m_tuser,   // [0] payload_valid, [1] size_ready
    input  logic              m_tlast,   // chunk_end
    output int                err_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX = LINE_LIMIT_DEF;

    // Parser state as the decoder should hold it
    logic [BODY_W-1:0] body_limit;
    phase_t            dec_phase;
    logic              cr_seen;
    logic [10:0]       line_len;
    logic [CLEN_W-1:0] size_acc;
    logic              size_seen;
    logic              in_ext;
    logic              bad_char;
    logic              size_ovf;
    logic [CLEN_W-1:0] chunk_left;
    logic [BODY_W-1:0] body_total;
    status_t           sticky;

    result_t expected_results[$];

    function automatic void clear_line();
        cr_seen   = 1'b0;
        line_len  = '0;
        size_acc  = '0;
        size_seen = 1'b0;
        in_ext    = 1'b0;
        bad_char  = 1'b0;
        size_ovf  = 1'b0;
    endfunction

    // Back to the start of a body; the size limit survives
    function automatic void restart_parser();
        dec_phase  = PH_SIZE;
        clear_line();
        chunk_left = '0;
        body_total = '0;
        sticky     = ST_OK;
    endfunction

    // Advance the parser by one input item and return the result it gives
    function automatic result_t decode_byte(input logic op, input logic [7:0] c);
        result_t    r;
        logic [4:0] nib;
        r        = '0;
        r.status = ST_OK;
        nib      = '0;
        if (op == OP_RESTART) begin
            restart_parser();
        end else if (sticky != ST_OK) begin
            r.status = ST_HALTED;
        end else if (dec_phase == PH_DONE) begin
            r.status = ST_REFUSED;
        end else if (dec_phase == PH_DATA) begin
            r.payload_byte  = c;
            r.payload_valid = 1'b1;
            if (body_total != '1) body_total = body_total + 1'b1;
            if (chunk_left != '0) chunk_left = chunk_left - 1'b1;
            if (chunk_left == '0) begin
                r.chunk_end = 1'b1;
                dec_phase   = PH_DATA_CRLF;
                cr_seen     = 1'b0;
            end
        end else if (dec_phase == PH_DATA_CRLF) begin
            // payload must be closed by CR LF
            if (!cr_seen) begin
                if (c != CH_CR) r.status = ST_FORMAT;
                else cr_seen = 1'b1;
            end else if (c != CH_LF) begin
                r.status = ST_FORMAT;
            end else begin
                clear_line();
                chunk_left = '0;
                dec_phase  = PH_SIZE;
            end
        end else if (cr_seen) begin
            // end of a size or trailer line
            cr_seen = 1'b0;
            if (c != CH_LF) begin
                r.status = ST_FORMAT;
            end else if (dec_phase == PH_TRAILER) begin
                if (line_len != '0) begin
                    r.status = ST_FORMAT;
                end else begin
                    dec_phase = PH_DONE;
                    r.status  = ST_COMPLETE;
                end
            end else if (!size_seen) begin
                r.status = ST_SYNTAX;
            end else if (size_ovf) begin
                r.status = ST_LENGTH;
            end else if (bad_char) begin
                r.status = ST_SYNTAX;
            end else if (size_acc != '0 && body_limit != '0 &&
                         (body_total > body_limit || size_acc > body_limit - body_total)) begin
                r.status = ST_LARGE;
            end else begin
                r.size_ready   = 1'b1;
                r.chunk_length = size_acc;
                chunk_left     = size_acc;
                dec_phase      = (size_acc == '0) ? PH_TRAILER : PH_DATA;
                clear_line();
            end
        end else if (c == CH_CR) begin
            cr_seen = 1'b1;
        end else if (c == CH_LF) begin
            r.status = ST_FORMAT;
        end else if (line_len >= 11'(LINE_MAX)) begin
            r.status = ST_LENGTH;
        end else begin
            line_len = line_len + 11'd1;
            if (dec_phase == PH_SIZE && !in_ext) begin
                if (c == CH_SEMI) begin
                    in_ext = 1'b1;
                end else begin
                    size_seen = 1'b1;
                    if (!bad_char && !size_ovf) begin
                        // digits keep their low nibble, letters add nine to it
                        if (c >= CH_0 && c <= CH_9) begin
                            nib = {1'b1, c[3:0]};
                        end else if ((c >= CH_A_LO && c <= CH_F_LO) ||
                                     (c >= CH_A_UP && c <= CH_F_UP)) begin
                            nib = {1'b1, c[3:0] + 4'd9};
                        end
                        if (!nib[4]) bad_char = 1'b1;
                        else if (size_acc[CLEN_W-1 -: 4] != 4'd0) size_ovf = 1'b1;
                        else size_acc = {size_acc[CLEN_W-5:0], nib[3:0]};
                    end
                end
            end
        end
        if (r.status >= ST_FORMAT && r.status <= ST_LARGE) sticky = r.status;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            body_limit = '0;
            restart_parser();
            expected_results.delete();
        end else begin
            // compare a result transfer with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no prediction waiting");
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
                    check_field("payload_valid", want.payload_valid, m_tuser[0]);
                    check_field("chunk_end", want.chunk_end, m_tlast);
                    check_field("size_ready", want.size_ready, m_tuser[1]);
                    check_field("chunk_length", want.chunk_length, m_tdata[39:8]);
                    check_field("status", want.status, m_tdata[42:40]);
                end
            end
            if (cfg_we) body_limit = cfg_wdata;
            // predict on every input transfer
            if (s_tvalid && s_tready) begin
                expected_results.insert(expected_results.size(),
                                        decode_byte(s_tuser, s_tdata));
            end
        end
        pending = expected_results.size();
    end

endmodule

// File: test/tb_chunked_body_stream_decoder_unit.sv
// Testbench top for the chunked body decoder: drives byte streams and reports the verdict.
module tb_chunked_body_stream_decoder_unit;
    import chbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int HOLD_CYCLES = 40;
    localparam int SEG_ITEMS   = 50;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {
        FLT_BARE_LF,
        FLT_CR_NO_LF,
        FLT_NO_CRLF,
        FLT_TRAILER,
        FLT_BAD_HEX,
        FLT_EMPTY_SIZE,
        FLT_OVERFLOW,
        FLT_TOO_LARGE,
        FLT_NOISE,
        FLT_RESTART_MID,
        FLT_COUNT
    } fault_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [BODY_W-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic              s_tuser   = OP_BYTE;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [47:0]       m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    int          err_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_req      = 1'b0;
    int          sent_items    = 0;
    int          cycle_count   = 0;
    logic [31:0] cur_limit     = '0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    chunked_body_stream_decoder_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    chbd_stream_checker chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .err_count (err_count),
        .pending   (pending)
    );

    // End the run if it hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when asked
    initial begin : receiver
        int k;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one item, idling first at random, and hold it until the transfer
    task automatic send_item(input logic op, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(OP_BYTE, b);
    endtask

    task automatic send_restart();
        send_item(OP_RESTART, 8'($urandom));
    endtask

    task automatic send_crlf();
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) send_byte(t[i]);
    endtask

    task automatic send_payload(input int len);
        repeat (len) send_byte(8'($urandom));
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [31:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_limit = v;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return CH_0 + 8'(nib);
        return (($urandom_range(0, 1) != 0) ? CH_A_UP : CH_A_LO) + 8'(nib - 4'd10);
    endfunction

    // Any byte that does not end a line
    function automatic logic [7:0] ext_byte();
        logic [7:0] b;
        b = 8'($urandom);
        while (b == CH_CR || b == CH_LF) b = 8'($urandom);
        return b;
    endfunction

    // Random byte with CR and LF made frequent
    function automatic logic [7:0] noisy_byte();
        case ($urandom_range(0, 3))
            0: return CH_CR;
            1: return CH_LF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(13, 64);
        return $urandom_range(1, 12);
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'($urandom_range(2, 64));
            3: return 32'hFFFF_FFFF;
            default: return 32'($urandom);
        endcase
    endfunction

    // Size line: optional leading zeros, hex digits in mixed case, optional extension
    task automatic send_size_line(input logic [31:0] value, input int zeros, input bit with_ext);
        int nd;
        nd = 1;
        while (nd < 8 && (value >> (4 * nd)) != 0) nd++;
        repeat (zeros) send_byte(CH_0);
        for (int k = nd - 1; k >= 0; k--) send_byte(hex_char(value[4*k +: 4]));
        if (with_ext) begin
            send_byte(CH_SEMI);
            repeat ($urandom_range(0, 6)) send_byte(ext_byte());
        end
        send_crlf();
    endtask

    task automatic send_chunk(input int len);
        send_size_line(len, ($urandom_range(0, 4) == 0) ? 1 : 0, $urandom_range(0, 3) == 0);
        send_payload(len);
        send_crlf();
    endtask

    // Well-formed body, occasionally changing the limit between chunks, then at times stray bytes and a restart
    task automatic good_body();
        repeat ($urandom_range(0, 3)) begin
            send_chunk(pick_len());
            if ($urandom_range(0, 11) == 0) set_limit(pick_limit());
        end
        send_size_line(32'd0, $urandom_range(0, 2), $urandom_range(0, 3) == 0);
        send_crlf();
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) send_byte(noisy_byte());
        send_restart();
    endtask

    // Body broken or cut short in one way, then up to two noisy bytes and a restart
    task automatic faulty_body();
        fault_t     kind;
        int         len;
        logic [7:0] b;
        kind = fault_t'($urandom_range(0, int'(FLT_COUNT) - 1));
        len  = pick_len();
        if ($urandom_range(0, 1) != 0) send_chunk(pick_len());
        case (kind)
            FLT_BARE_LF: begin
                send_byte(hex_char(4'($urandom)));
                send_byte(CH_LF);
            end
            FLT_CR_NO_LF: begin
                send_byte(hex_char(4'($urandom)));
                send_byte(CH_CR);
                b = 8'($urandom);
                send_byte((b == CH_LF) ? CH_CR : b);
            end
            FLT_NO_CRLF: begin
                send_size_line(len, 0, 1'b0);
                send_payload(len);
                b = 8'($urandom);
                if ($urandom_range(0, 1) != 0) begin
                    send_byte((b == CH_CR) ? CH_LF : b);
                end else begin
                    send_byte(CH_CR);
                    send_byte((b == CH_LF) ? CH_CR : b);
                end
            end
            FLT_TRAILER: begin
                send_size_line(32'd0, 0, 1'b0);
                repeat ($urandom_range(1, 4)) send_byte(ext_byte());
                send_crlf();
            end
            FLT_BAD_HEX: begin
                if ($urandom_range(0, 1) != 0) send_byte(hex_char(4'($urandom)));
                b = ext_byte();
                while (b == CH_SEMI || (b >= CH_0 && b <= CH_9) ||
                       (b >= CH_A_LO && b <= CH_F_LO) || (b >= CH_A_UP && b <= CH_F_UP)) begin
                    b = ext_byte();
                end
                send_byte(b);
                repeat ($urandom_range(0, 2)) send_byte(hex_char(4'($urandom)));
                send_crlf();
            end
            FLT_EMPTY_SIZE: begin
                if ($urandom_range(0, 1) != 0) begin
                    send_byte(CH_SEMI);
                    send_byte(ext_byte());
                end
                send_crlf();
            end
            FLT_OVERFLOW: begin
                if ($urandom_range(0, 1) != 0) begin
                    // more significant digits than the size field holds
                    send_byte(hex_char(4'($urandom_range(1, 15))));
                    repeat (8 + $urandom_range(0, 2)) send_byte(hex_char(4'($urandom)));
                    send_crlf();
                end else begin
                    // widest size that still fits, cut short by the restart
                    send_size_line(32'hFFFF_FFFF - 32'($urandom_range(0, 15)),
                                   $urandom_range(0, 2), 1'b0);
                    send_payload($urandom_range(1, 4));
                end
            end
            FLT_TOO_LARGE: begin
                send_size_line(cur_limit + 32'd1, 0, 1'b0);
                send_payload(2);
            end
            FLT_NOISE: begin
                repeat ($urandom_range(3, 10)) send_byte(noisy_byte());
            end
            FLT_RESTART_MID: begin
                send_size_line(len, 0, 1'b0);
                send_payload($urandom_range(0, len - 1));
            end
            default: ;
        endcase
        repeat ($urandom_range(0, 2)) send_byte(noisy_byte());
        send_restart();
    endtask

    initial begin : stimulus
        int seg;
        int seg_end;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        set_limit(32'd0);

        // Directed: both byte extremes in a chunk, completion, refusal, restart
        send_text("2");
        send_crlf();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_crlf();
        send_text("0");
        send_crlf();
        send_crlf();
        send_byte(CH_SEMI);
        send_restart();
        // bare LF halts the parser until a restart
        send_byte(CH_LF);
        send_byte(CH_0);
        send_restart();
        // non-hex size text
        send_text("G");
        send_crlf();
        send_restart();

        // Random bodies in three idling regimes
        for (seg = 0; seg < 3; seg++) begin
            case (seg)
                0: begin
                    send_idle_pct = 22;
                    recv_idle_pct = 58;
                end
                1: begin
                    send_idle_pct = 58;
                    recv_idle_pct = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            set_limit((seg == 0) ? 32'd0 :
                      (seg == 1) ? 32'($urandom_range(20, 80)) : 32'hFFFF_FFFF);
            hold_req = 1'b1;
            if (seg == 2) begin
                // size line one byte over the line limit
                send_byte(hex_char(4'd3));
                send_byte(CH_SEMI);
                repeat (LINE_LIMIT_DEF - 1) send_byte(ext_byte());
                send_crlf();
                send_restart();
            end
            seg_end = sent_items + SEG_ITEMS;
            while (sent_items < seg_end) begin
                if ($urandom_range(0, 9) < 7) good_body();
                else faulty_body();
                if ($urandom_range(0, 29) == 0) wait_drained();
                if ($urandom_range(0, 39) == 0) hold_req = 1'b1;
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
